// ===== sv/hsv2rgb_pkg.sv =====
// shared types and constants for the hsv to rgb converter
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    // hue range and sector width in degrees
    localparam int unsigned HUE_MAX    = 360;
    localparam int unsigned SECTOR_DEG = 60;

    // 1.0 in the 256 * 60 scale used for (1 - s*n/60)
    localparam int unsigned ONE_SCALED = 15360;

    // full-scale channel value
    localparam int unsigned FULL_SCALE = 255;

    // quotient by 15 reaches full scale from this value up
    localparam int unsigned CLAMP_Y = 3840;

    // ceil(2^15 / 15), exact reciprocal for operands below CLAMP_Y
    localparam int unsigned RECIP15 = 2185;

    // hue sectors
    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } t_sector;

    // input item
    typedef struct packed {
        logic [8:0] hue;
        logic [8:0] saturation;
        logic [8:0] brightness;
    } t_hsv;

    // result item
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

endpackage

// ===== sv/hsv2rgb_chan.sv =====
// three-stage pipeline computing one channel term floor(255*v*(1 - s*n/(256*60))/256)
`timescale 1ns / 1ps

module hsv2rgb_chan (
    input  logic       i_clk,
    input  logic [8:0] i_sat,
    input  logic [8:0] i_val,
    input  logic [5:0] i_n,
    output logic [7:0] o_chan
);

    logic [14:0] sn;
    logic [13:0] n_m;
    logic [16:0] n_v255;
    logic [30:0] prod;
    logic [12:0] n_y;
    logic [23:0] recip_prod;
    logic [7:0]  n_chan;

    logic [13:0] r_m;
    logic [16:0] r_v255;
    logic [12:0] r_y;
    logic [7:0]  r_chan;

    // stage a: scaled (1 - s*n/60), negative clamps to zero, and 255*v
    always_comb begin
        sn = 15'(i_sat) * 15'(i_n);
        if (sn >= 15'(hsv2rgb_pkg::ONE_SCALED)) begin
            n_m = '0;
        end else begin
            n_m = 14'(15'(hsv2rgb_pkg::ONE_SCALED) - sn);
        end
        n_v255 = {i_val, 8'b0} - 17'(i_val);
    end

    // stage b: full product, then drop the power-of-two part (2^18) of the divisor
    always_comb begin
        prod = 31'(r_v255) * 31'(r_m);
        n_y  = prod[30:18];
    end

    // stage c: divide by 15 through the reciprocal, clamp to full scale
    always_comb begin
        recip_prod = 24'(r_y[11:0]) * 24'(hsv2rgb_pkg::RECIP15);
        if (r_y >= 13'(hsv2rgb_pkg::CLAMP_Y)) begin
            n_chan = 8'(hsv2rgb_pkg::FULL_SCALE);
        end else begin
            n_chan = recip_prod[22:15];
        end
    end

    // data registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_m    <= n_m;
        r_v255 <= n_v255;
        r_y    <= n_y;
        r_chan <= n_chan;
    end

    assign o_chan = r_chan;

endmodule

// ===== sv/hsv_to_rgb_top.sv =====
// hsv to rgb converter top level: hue decode, four channel pipelines, sector routing
// the result strobe o_valid is high while the routed result sits in the output register
// throughput: one colour per clock; five register stages (hue decode, three channel
// stages, output routing), the channel multipliers each own a stage
// o_busy is always low: the pipeline never stalls and the receiver cannot hold off
// reset (synchronous, active low) clears the valid bits only; data registers keep values
`timescale 1ns / 1ps

module hsv_to_rgb_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  hsv2rgb_pkg::t_hsv i_data,
    output logic              o_valid,
    output hsv2rgb_pkg::t_rgb o_result
);

    logic                 accept;
    logic [8:0]           hue_sat;
    hsv2rgb_pkg::t_sector n_sec;
    logic [8:0]           base;
    logic [5:0]           n_rem;

    hsv2rgb_pkg::t_sector r_sec;
    logic [5:0]           r_rem;
    logic [8:0]           r_s;
    logic [8:0]           r_v;
    hsv2rgb_pkg::t_sector r_sec_d [3];
    logic [4:0]           r_vld;

    logic [5:0]           n_q;
    logic [5:0]           n_t;
    logic [7:0]           cv;
    logic [7:0]           cp;
    logic [7:0]           cq;
    logic [7:0]           ct;
    hsv2rgb_pkg::t_rgb    n_result;
    hsv2rgb_pkg::t_rgb    r_result;

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    // hue saturation and sector decode
    always_comb begin
        if (i_data.hue > 9'(hsv2rgb_pkg::HUE_MAX)) begin
            hue_sat = 9'(hsv2rgb_pkg::HUE_MAX);
        end else begin
            hue_sat = i_data.hue;
        end
        if (hue_sat >= 9'(hsv2rgb_pkg::HUE_MAX)) begin
            n_sec = hsv2rgb_pkg::SEC_RED;
            base  = hue_sat;
        end else if (hue_sat >= 9'(5 * hsv2rgb_pkg::SECTOR_DEG)) begin
            n_sec = hsv2rgb_pkg::SEC_MAGENTA;
            base  = 9'(5 * hsv2rgb_pkg::SECTOR_DEG);
        end else if (hue_sat >= 9'(4 * hsv2rgb_pkg::SECTOR_DEG)) begin
            n_sec = hsv2rgb_pkg::SEC_BLUE;
            base  = 9'(4 * hsv2rgb_pkg::SECTOR_DEG);
        end else if (hue_sat >= 9'(3 * hsv2rgb_pkg::SECTOR_DEG)) begin
            n_sec = hsv2rgb_pkg::SEC_CYAN;
            base  = 9'(3 * hsv2rgb_pkg::SECTOR_DEG);
        end else if (hue_sat >= 9'(2 * hsv2rgb_pkg::SECTOR_DEG)) begin
            n_sec = hsv2rgb_pkg::SEC_GREEN;
            base  = 9'(2 * hsv2rgb_pkg::SECTOR_DEG);
        end else if (hue_sat >= 9'(hsv2rgb_pkg::SECTOR_DEG)) begin
            n_sec = hsv2rgb_pkg::SEC_YELLOW;
            base  = 9'(hsv2rgb_pkg::SECTOR_DEG);
        end else begin
            n_sec = hsv2rgb_pkg::SEC_RED;
            base  = '0;
        end
        n_rem = 6'(hue_sat - base);
    end

    // decode stage, sector delay line and output register, data only
    always_ff @(posedge i_clk) begin
        r_sec      <= n_sec;
        r_rem      <= n_rem;
        r_s        <= i_data.saturation;
        r_v        <= i_data.brightness;
        r_sec_d[0] <= r_sec;
        r_sec_d[1] <= r_sec_d[0];
        r_sec_d[2] <= r_sec_d[1];
        r_result   <= n_result;
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], accept};
        end
    end

    // fraction terms for q and t
    assign n_q = r_rem;
    assign n_t = 6'(hsv2rgb_pkg::SECTOR_DEG) - r_rem;

    // v, p, q and t channel pipelines
    hsv2rgb_chan u_chan_v (
        .i_clk  (i_clk),
        .i_sat  (r_s),
        .i_val  (r_v),
        .i_n    (6'd0),
        .o_chan (cv)
    );

    hsv2rgb_chan u_chan_p (
        .i_clk  (i_clk),
        .i_sat  (r_s),
        .i_val  (r_v),
        .i_n    (6'(hsv2rgb_pkg::SECTOR_DEG)),
        .o_chan (cp)
    );

    hsv2rgb_chan u_chan_q (
        .i_clk  (i_clk),
        .i_sat  (r_s),
        .i_val  (r_v),
        .i_n    (n_q),
        .o_chan (cq)
    );

    hsv2rgb_chan u_chan_t (
        .i_clk  (i_clk),
        .i_sat  (r_s),
        .i_val  (r_v),
        .i_n    (n_t),
        .o_chan (ct)
    );

    // route the terms to red, green and blue by sector
    always_comb begin
        unique case (r_sec_d[2])
            hsv2rgb_pkg::SEC_RED:     n_result = '{red: cv, green: ct, blue: cp};
            hsv2rgb_pkg::SEC_YELLOW:  n_result = '{red: cq, green: cv, blue: cp};
            hsv2rgb_pkg::SEC_GREEN:   n_result = '{red: cp, green: cv, blue: ct};
            hsv2rgb_pkg::SEC_CYAN:    n_result = '{red: cp, green: cq, blue: cv};
            hsv2rgb_pkg::SEC_BLUE:    n_result = '{red: ct, green: cp, blue: cv};
            hsv2rgb_pkg::SEC_MAGENTA: n_result = '{red: cv, green: cp, blue: cq};
            default:                  n_result = '{red: cv, green: cp, blue: cq};
        endcase
    end

    assign o_valid  = r_vld[4];
    assign o_result = r_result;

    // every accepted transfer is followed by its result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##5 o_valid)
        else $error("result strobe missing after accepted transfer");

    // no result without an accepted transfer
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 5))
        else $error("result strobe without accepted transfer");

    // zero saturation gives a gray result
    a_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_data.saturation, 5) == 9'd0) |->
        (o_result.red == o_result.green && o_result.green == o_result.blue))
        else $error("zero saturation did not give gray");

    // zero brightness gives black
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_data.brightness, 5) == 9'd0) |->
        (o_result.red == 8'd0 && o_result.green == 8'd0 && o_result.blue == 8'd0))
        else $error("zero brightness did not give black");

endmodule
